/* hdl/brb_pkg.sv */
// ---------------------------------------------------------------------------
// brb_pkg
// Shared types and codes for the byte ring buffer.
// ---------------------------------------------------------------------------
package brb_pkg;

    typedef enum logic [1:0] {
        CMD_ENQ   = 2'd0,
        CMD_DEQ   = 2'd1,
        CMD_PEEK  = 2'd2,
        CMD_CLEAR = 2'd3
    } t_cmd;

    typedef enum logic [2:0] {
        STS_DATA    = 3'd0,
        STS_NOTHING = 3'd1,
        STS_ACCEPT  = 3'd2,
        STS_REJECT  = 3'd3,
        STS_CLEARED = 3'd4
    } t_status;

    typedef enum logic {
        S_IDLE = 1'b0,
        S_READ = 1'b1
    } t_state;

    localparam int unsigned CountW = 7;
    localparam int unsigned LevelW = 10;

endpackage

/* hdl/byte_ring_buffer.sv */
// ---------------------------------------------------------------------------
// byte_ring_buffer
// Byte FIFO on a circular buffer memory with all-or-nothing enqueue transfers.
// ---------------------------------------------------------------------------
// Usage: present a command with start high while busy is low; it is taken at
// that clock edge. Enqueue and clear give one result beat, with o_strobe high
// for one cycle, on the cycle after the command is taken; a new command may
// follow every cycle, so enqueue runs at one byte per clock.
// Dequeue and peek of n bytes (n = min(count, MAX_BURST, stored)) hold busy
// while the memory's single read port walks the entries; the data beats
// follow one per cycle, the first once the read address and then the memory
// output are registered, and no new command is taken until the walk ends.
// A read with nothing to return gives one beat like an enqueue.
// Enqueued bytes of a transfer are written behind the committed end and
// become visible when its last byte arrives.
// Reset (synchronous, active low) empties the buffer and drops any transfer;
// no memory clearing pass is needed. Results are not held off by the
// receiver: every beat is shown for exactly one cycle.
// ---------------------------------------------------------------------------
module byte_ring_buffer #(
    parameter int unsigned DEPTH     = 1024,
    parameter int unsigned MAX_BURST = 64
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        start,
    output logic        busy,
    input  logic [1:0]  i_command,
    input  logic [7:0]  i_data_in,
    input  logic [6:0]  i_count,
    input  logic        i_first,
    output logic        o_strobe,
    output logic [7:0]  o_data_out,
    output logic        o_last,
    output logic [2:0]  o_status,
    output logic [9:0]  o_used,
    output logic [9:0]  o_free
);

    localparam int unsigned AW   = (DEPTH > 2) ? $clog2(DEPTH) : 1;
    localparam int unsigned AW1  = AW + 1;
    localparam int unsigned CMPW = (AW > brb_pkg::CountW) ? AW : brb_pkg::CountW;

    localparam logic [AW-1:0]  TopIdx   = AW'(DEPTH - 1);
    localparam logic [AW1-1:0] DepthW   = AW1'(DEPTH);
    localparam logic [6:0]     BurstMax = 7'(MAX_BURST);

    function automatic logic [AW-1:0] f_inc(input logic [AW-1:0] p);
        return (p == TopIdx) ? '0 : p + 1'b1;
    endfunction

    // storage
    logic [7:0] r_mem [DEPTH];
    logic [7:0] r_mem_q;

    // control state
    brb_pkg::t_state  r_state, n_state;
    logic [AW-1:0]    r_rp, n_rp;
    logic [AW-1:0]    r_wp, n_wp;
    logic [AW-1:0]    r_stage, n_stage;
    logic [AW-1:0]    r_count, n_count;
    logic [6:0]       r_rem, n_rem;
    logic             r_acc, n_acc;
    logic [6:0]       r_len, n_len;

    // read walk
    logic [AW-1:0]    r_rd_addr, n_rd_addr;
    logic [6:0]       r_left, n_left;

    // result beat
    logic             r_strobe, n_strobe;
    logic             r_last, n_last;
    brb_pkg::t_status r_status, n_status;
    logic [9:0]       r_used, n_used;
    logic [9:0]       r_free, n_free;

    logic             mem_we;
    logic [AW-1:0]    mem_waddr;
    logic             accept;
    logic [AW-1:0]    free_now;
    logic [6:0]       cnt_clip;
    logic [6:0]       rd_n;
    logic [AW1-1:0]   rp_sum;

    assign accept   = start && (r_state == brb_pkg::S_IDLE);
    assign free_now = TopIdx - r_count;
    assign cnt_clip = (i_count > BurstMax) ? BurstMax : i_count;
    assign rd_n     = (CMPW'(cnt_clip) > CMPW'(r_count)) ? 7'(r_count) : cnt_clip;
    assign rp_sum   = {1'b0, r_rp} + AW1'(rd_n);

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            brb_pkg::S_IDLE: begin
                if (accept && rd_n != 7'd0 &&
                    (brb_pkg::t_cmd'(i_command) == brb_pkg::CMD_DEQ ||
                     brb_pkg::t_cmd'(i_command) == brb_pkg::CMD_PEEK)) begin
                    n_state = brb_pkg::S_READ;
                end
            end
            brb_pkg::S_READ: begin
                if (r_left == 7'd1) begin
                    n_state = brb_pkg::S_IDLE;
                end
            end
            default: n_state = brb_pkg::S_IDLE;
        endcase
    end

    // datapath next values
    always_comb begin
        n_rp      = r_rp;
        n_wp      = r_wp;
        n_stage   = r_stage;
        n_count   = r_count;
        n_rem     = r_rem;
        n_acc     = r_acc;
        n_len     = r_len;
        n_rd_addr = r_rd_addr;
        n_left    = r_left;
        n_strobe  = 1'b0;
        n_last    = r_last;
        n_status  = r_status;
        n_used    = r_used;
        n_free    = r_free;
        mem_we    = 1'b0;
        mem_waddr = r_stage;

        case (r_state)
            brb_pkg::S_IDLE: begin
                if (accept) begin
                    n_last = 1'b1;
                    case (brb_pkg::t_cmd'(i_command))
                        brb_pkg::CMD_ENQ: begin
                            n_strobe = 1'b1;
                            n_status = brb_pkg::STS_REJECT;
                            if (i_first) begin
                                // a new first abandons any open transfer
                                n_acc = 1'b0;
                                n_rem = 7'd0;
                                if (i_count != 7'd0) begin
                                    n_rem = i_count - 7'd1;
                                    if (i_count <= BurstMax &&
                                        CMPW'(i_count) <= CMPW'(free_now)) begin
                                        mem_we    = 1'b1;
                                        mem_waddr = r_wp;
                                        n_stage   = f_inc(r_wp);
                                        n_len     = i_count;
                                        n_status  = brb_pkg::STS_ACCEPT;
                                        if (n_rem == 7'd0) begin
                                            n_wp    = f_inc(r_wp);
                                            n_count = r_count + AW'(i_count);
                                        end else begin
                                            n_acc = 1'b1;
                                        end
                                    end
                                end
                            end else if (r_rem != 7'd0) begin
                                n_rem = r_rem - 7'd1;
                                if (r_acc) begin
                                    mem_we   = 1'b1;
                                    n_stage  = f_inc(r_stage);
                                    n_status = brb_pkg::STS_ACCEPT;
                                    if (n_rem == 7'd0) begin
                                        // last byte: commit the whole transfer
                                        n_wp    = f_inc(r_stage);
                                        n_acc   = 1'b0;
                                        n_count = r_count + AW'(r_len);
                                    end
                                end
                            end
                        end
                        brb_pkg::CMD_CLEAR: begin
                            n_strobe = 1'b1;
                            n_status = brb_pkg::STS_CLEARED;
                            n_rp     = '0;
                            n_wp     = '0;
                            n_stage  = '0;
                            n_count  = '0;
                            n_rem    = 7'd0;
                            n_acc    = 1'b0;
                        end
                        brb_pkg::CMD_DEQ, brb_pkg::CMD_PEEK: begin
                            if (rd_n == 7'd0) begin
                                n_strobe = 1'b1;
                                n_status = brb_pkg::STS_NOTHING;
                            end else begin
                                n_rd_addr = r_rp;
                                n_left    = rd_n;
                                if (brb_pkg::t_cmd'(i_command) == brb_pkg::CMD_DEQ) begin
                                    n_rp    = (rp_sum >= DepthW) ? AW'(rp_sum - DepthW)
                                                                 : AW'(rp_sum);
                                    n_count = r_count - AW'(rd_n);
                                end
                            end
                        end
                        default: n_strobe = 1'b0;
                    endcase
                    n_used = 10'(n_count);
                    n_free = 10'(TopIdx - n_count);
                end
            end
            brb_pkg::S_READ: begin
                // memory read issued this edge, beat shown next cycle
                n_strobe  = 1'b1;
                n_status  = brb_pkg::STS_DATA;
                n_last    = (r_left == 7'd1);
                n_rd_addr = f_inc(r_rd_addr);
                n_left    = r_left - 7'd1;
            end
            default: n_strobe = 1'b0;
        endcase
    end

    // outputs
    always_comb begin
        busy       = (r_state != brb_pkg::S_IDLE);
        o_strobe   = r_strobe;
        o_data_out = (r_status == brb_pkg::STS_DATA) ? r_mem_q : 8'd0;
        o_last     = r_last;
        o_status   = r_status;
        o_used     = r_used;
        o_free     = r_free;
    end

    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            r_mem[mem_waddr] <= i_data_in;
        end
        r_mem_q <= r_mem[r_rd_addr];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= brb_pkg::S_IDLE;
            r_rp     <= '0;
            r_wp     <= '0;
            r_stage  <= '0;
            r_count  <= '0;
            r_rem    <= 7'd0;
            r_acc    <= 1'b0;
            r_strobe <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_rp     <= n_rp;
            r_wp     <= n_wp;
            r_stage  <= n_stage;
            r_count  <= n_count;
            r_rem    <= n_rem;
            r_acc    <= n_acc;
            r_strobe <= n_strobe;
        end
    end

    always_ff @(posedge i_clk) begin
        r_len     <= n_len;
        r_rd_addr <= n_rd_addr;
        r_left    <= n_left;
        r_last    <= n_last;
        r_status  <= n_status;
        r_used    <= n_used;
        r_free    <= n_free;
    end

endmodule
